@@ src/kt_pkg.sv @@
// shared types and constants for the key table
package kt_pkg;

    localparam int SLOTS_DEF = 128;
    localparam int KEY_W = 32;

    localparam logic [KEY_W-1:0] MARK_NEVER_USED = 32'h3D3D_3D3D;
    localparam logic [KEY_W-1:0] MARK_ERASED     = 32'h2D2D_2D2D;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } kt_op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } kt_status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } kt_state_t;

    typedef struct packed {
        logic key_hit;
        logic never_hit;
        logic erased_hit;
    } kt_match_t;

endpackage

@@ src/kt_ram.sv @@
// generic single write port ram with registered read
module kt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/kt_cmp.sv @@
// shared compare unit: slot word against key and both markers
module kt_cmp
    import kt_pkg::*;
(
    input  logic [KEY_W-1:0] slot_word,
    input  logic [KEY_W-1:0] key,
    output kt_match_t        match
);

    always_comb begin
        match.key_hit    = (slot_word == key);
        match.never_hit  = (slot_word == MARK_NEVER_USED);
        match.erased_hit = (slot_word == MARK_ERASED);
    end

endmodule

@@ src/key_table_with_tombstones.sv @@
// top level of the card key table with erased-slot markers
//
// usage: each transfer on the s_ channel carries an operation in s_tuser
// (lookup, insert, remove, clear) and a 32-bit card key in s_tdata. every
// accepted transfer produces exactly one status transfer on the m_ channel
// (ok or found, already present or not found, table full).
// the slots live in one ram read one word per cycle. lookup, insert and
// remove scan all SLOTS slots through the shared compare unit, then write
// back at most one slot before the result is sent. clear writes the
// never-used marker into one slot per cycle. s_tready is
// high only while the sequencer is idle. after reset the same clearing
// pass runs with s_tready low. a result waits in the output register
// while m_tready is low; the next item may be accepted meanwhile, and its
// result is held until the output register is free.
module key_table_with_tombstones
    import kt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] card_key
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [1:0] status, [7:2] zero
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [AW:0]   CNT_END  = (AW+1)'(SLOTS);
    localparam logic [AW-1:0] IDX_LAST = AW'(SLOTS - 1);

    kt_state_t state_reg, state_next;
    logic [AW:0]      cnt_reg, cnt_next;
    kt_op_t           op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             resp_reg, resp_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [AW-1:0]    chk_idx_reg, chk_idx_next;
    logic             key_found_reg, key_found_next;
    logic [AW-1:0]    key_idx_reg, key_idx_next;
    logic             never_found_reg, never_found_next;
    logic [AW-1:0]    never_idx_reg, never_idx_next;
    logic             erased_found_reg, erased_found_next;
    logic [AW-1:0]    erased_idx_reg, erased_idx_next;
    kt_status_t       status_reg, status_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [1:0]       m_status_reg, m_status_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic             ram_re;
    logic [KEY_W-1:0] ram_rdata;
    kt_match_t        match;

    logic s_fire, scan_issue, scan_end, out_free, clr_last;

    assign s_fire     = s_tvalid && s_tready;
    assign scan_issue = (cnt_reg != CNT_END);
    assign scan_end   = !scan_issue && !chk_valid_reg;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign clr_last   = (cnt_reg[AW-1:0] == IDX_LAST);

    kt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    kt_cmp u_cmp (
        .slot_word (ram_rdata),
        .key       (key_reg),
        .match     (match)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_last) begin
                    state_next = resp_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    state_next = (kt_op_t'(s_tuser) == OP_CLEAR) ? S_CLEAR : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[AW-1:0];
        ram_wdata = MARK_NEVER_USED;
        ram_re    = 1'b0;
        case (state_reg)
            S_CLEAR: ram_we = 1'b1;
            S_IDLE:  s_tready = 1'b1;
            S_SCAN:  ram_re = scan_issue;
            S_DECIDE: begin
                case (op_reg)
                    OP_INSERT: begin
                        ram_wdata = key_reg;
                        if (!key_found_reg && never_found_reg) begin
                            ram_we    = 1'b1;
                            ram_waddr = never_idx_reg;
                        end else if (!key_found_reg && erased_found_reg) begin
                            ram_we    = 1'b1;
                            ram_waddr = erased_idx_reg;
                        end
                    end
                    OP_REMOVE: begin
                        ram_wdata = MARK_ERASED;
                        ram_we    = key_found_reg;
                        ram_waddr = key_idx_reg;
                    end
                    default: ram_we = 1'b0;
                endcase
            end
            default: s_tready = 1'b0;
        endcase
    end

    // datapath next values
    always_comb begin
        cnt_next          = cnt_reg;
        op_next           = op_reg;
        key_next          = key_reg;
        resp_next         = resp_reg;
        chk_valid_next    = 1'b0;
        chk_idx_next      = cnt_reg[AW-1:0];
        key_found_next    = key_found_reg;
        key_idx_next      = key_idx_reg;
        never_found_next  = never_found_reg;
        never_idx_next    = never_idx_reg;
        erased_found_next = erased_found_reg;
        erased_idx_next   = erased_idx_reg;
        status_next       = status_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_status_next     = m_status_reg;
        case (state_reg)
            S_CLEAR: cnt_next = cnt_reg + 1'b1;
            S_IDLE: begin
                if (s_fire) begin
                    op_next           = kt_op_t'(s_tuser);
                    key_next          = s_tdata;
                    cnt_next          = '0;
                    resp_next         = 1'b1;
                    status_next       = ST_OK;
                    key_found_next    = 1'b0;
                    never_found_next  = 1'b0;
                    erased_found_next = 1'b0;
                end
            end
            S_SCAN: begin
                if (scan_issue) begin
                    cnt_next       = cnt_reg + 1'b1;
                    chk_valid_next = 1'b1;
                end
                if (chk_valid_reg) begin
                    if (!key_found_reg && match.key_hit) begin
                        key_found_next = 1'b1;
                        key_idx_next   = chk_idx_reg;
                    end
                    if (!never_found_reg && match.never_hit) begin
                        never_found_next = 1'b1;
                        never_idx_next   = chk_idx_reg;
                    end
                    if (!erased_found_reg && match.erased_hit) begin
                        erased_found_next = 1'b1;
                        erased_idx_next   = chk_idx_reg;
                    end
                end
            end
            S_DECIDE: begin
                case (op_reg)
                    OP_LOOKUP, OP_REMOVE: status_next = key_found_reg ? ST_OK : ST_MISS;
                    OP_INSERT: begin
                        if (key_found_reg) begin
                            status_next = ST_MISS;
                        end else if (never_found_reg || erased_found_reg) begin
                            status_next = ST_OK;
                        end else begin
                            status_next = ST_FULL;
                        end
                    end
                    default: status_next = ST_OK;
                endcase
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                end
            end
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            resp_reg      <= 1'b0;
            chk_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            resp_reg      <= resp_next;
            chk_valid_reg <= chk_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg           <= op_next;
        key_reg          <= key_next;
        chk_idx_reg      <= chk_idx_next;
        key_found_reg    <= key_found_next;
        key_idx_reg      <= key_idx_next;
        never_found_reg  <= never_found_next;
        never_idx_reg    <= never_idx_next;
        erased_found_reg <= erased_found_next;
        erased_idx_reg   <= erased_idx_next;
        status_reg       <= status_next;
        m_status_reg     <= m_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_status_reg};

endmodule
